// ===== sv/clns_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clns_pkg
// Shared types, constants and script tables of the LCD nibble sequencer.
// ---------------------------------------------------------------------------
package clns_pkg;

  typedef enum logic [1:0] {
    MODE_CMD    = 2'd0,
    MODE_DATA   = 2'd1,
    MODE_CURSOR = 2'd2,
    MODE_RESET  = 2'd3
  } mode_t;

  typedef enum logic [0:0] {
    CFG_DISPLAY_FLAGS = 1'b0,
    CFG_ENTRY_FLAGS   = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PRE  = 3'b010,
    ST_NIB  = 3'b100
  } state_t;

  localparam int unsigned NIB_W   = 4;
  localparam int unsigned PHASE_W = 2;

  localparam logic [NIB_W-1:0]   SCRIPT_LAST_NIB = 4'd13;
  localparam logic [NIB_W-1:0]   BYTE_LAST_NIB   = 4'd1;
  localparam logic [PHASE_W-1:0] PH_PLAIN = 2'd0;
  localparam logic [PHASE_W-1:0] PH_EN_HI = 2'd1;
  localparam logic [PHASE_W-1:0] PH_EN_LO = 2'd2;

  localparam logic [7:0]  PORT_ENABLE  = 8'h04;
  localparam logic [15:0] WAIT_POWERUP = 16'd1000;
  localparam logic [15:0] WAIT_LONG    = 16'd4500;
  localparam logic [15:0] WAIT_SHORT   = 16'd120;
  localparam logic [15:0] WAIT_CLEAR   = 16'd2000;
  localparam logic [15:0] WAIT_NONE    = 16'd0;

  localparam logic [2:0] DISPLAY_FLAGS_RST = 3'd4;
  localparam logic [1:0] ENTRY_FLAGS_RST   = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic               load;
    logic               emit;
    logic               pre;
    logic               script;
    logic [NIB_W-1:0]   nib;
    logic [PHASE_W-1:0] phase;
    logic               last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } status_t;

  function automatic logic [6:0] row_offset(input logic [1:0] row);
    logic [6:0] off;
    unique case (row)
      2'd0:    off = 7'h00;
      2'd1:    off = 7'h40;
      2'd2:    off = 7'h14;
      default: off = 7'h54;
    endcase
    return off;
  endfunction

  // Nibbles of the init script, in send order.
  function automatic logic [3:0] script_nibble(input logic [NIB_W-1:0] n,
                                               input logic [2:0] df,
                                               input logic [1:0] ef);
    logic [3:0] v;
    unique case (n)
      4'd0, 4'd1, 4'd2: v = 4'h3;
      4'd3, 4'd4:       v = 4'h2;   // 4-bit switch, then 0x28 high
      4'd5:             v = 4'h8;
      4'd7:             v = {1'b1, df};
      4'd9:             v = 4'h1;
      4'd11:            v = {2'b01, ef};
      4'd13:            v = 4'h2;
      default:          v = 4'h0;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] script_wait(input logic [NIB_W-1:0] n);
    logic [15:0] w;
    unique case (n)
      4'd0, 4'd1:  w = WAIT_LONG;
      4'd2:        w = WAIT_SHORT;
      4'd9, 4'd13: w = WAIT_CLEAR;
      default:     w = WAIT_NONE;
    endcase
    return w;
  endfunction

endpackage

// ===== sv/clns_req_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clns_req_if
// Request channel: valid/ready with mode, value, row and col.
// ---------------------------------------------------------------------------
interface clns_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] value;
  logic [1:0] row;
  logic [5:0] col;

  modport source (output valid, mode, value, row, col, input ready);
  modport sink   (input valid, mode, value, row, col, output ready);
endinterface

// ===== sv/clns_res_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clns_res_if
// Result channel: valid/ready with port byte, wait time and last flag.
// ---------------------------------------------------------------------------
interface clns_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  port_byte;
  logic [15:0] wait_us;
  logic        last;

  modport source (output valid, port_byte, wait_us, last, input ready);
  modport sink   (input valid, port_byte, wait_us, last, output ready);
endinterface

// ===== sv/clns_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clns_ctrl
// Sequencer FSM: walks nibbles and enable phases of one request.
// ---------------------------------------------------------------------------
module clns_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_mode,
  output logic               in_ready,
  input  clns_pkg::status_t  sts,
  output clns_pkg::cmd_t     cmd
);

  clns_pkg::state_t                  state_r, state_nxt;
  logic [clns_pkg::NIB_W-1:0]        nib_r, nib_nxt;
  logic [clns_pkg::PHASE_W-1:0]      phase_r, phase_nxt;
  logic                              script_r, script_nxt;
  logic                              last_nib;

  assign in_ready = (state_r == clns_pkg::ST_IDLE);
  assign last_nib = (nib_r == (script_r ? clns_pkg::SCRIPT_LAST_NIB
                                        : clns_pkg::BYTE_LAST_NIB));

  always_comb begin
    state_nxt  = state_r;
    nib_nxt    = nib_r;
    phase_nxt  = phase_r;
    script_nxt = script_r;
    cmd        = '0;
    cmd.script = script_r;
    cmd.nib    = nib_r;
    cmd.phase  = phase_r;
    unique case (state_r)
      clns_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          nib_nxt    = '0;
          phase_nxt  = clns_pkg::PH_PLAIN;
          script_nxt = (clns_pkg::mode_t'(in_mode) == clns_pkg::MODE_RESET);
          state_nxt  = script_nxt ? clns_pkg::ST_PRE : clns_pkg::ST_NIB;
        end
      end
      clns_pkg::ST_PRE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.pre   = 1'b1;
          state_nxt = clns_pkg::ST_NIB;
        end
      end
      clns_pkg::ST_NIB: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (phase_r == clns_pkg::PH_EN_LO) begin
            cmd.last  = last_nib;
            phase_nxt = clns_pkg::PH_PLAIN;
            nib_nxt   = nib_r + 1'b1;
            if (last_nib) begin
              state_nxt = clns_pkg::ST_IDLE;
            end
          end else begin
            phase_nxt = phase_r + 1'b1;
          end
        end
      end
      default: state_nxt = clns_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= clns_pkg::ST_IDLE;
      nib_r    <= '0;
      phase_r  <= clns_pkg::PH_PLAIN;
      script_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      nib_r    <= nib_nxt;
      phase_r  <= phase_nxt;
      script_r <= script_nxt;
    end
  end

endmodule

// ===== sv/clns_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clns_dp
// Datapath: config regs, held request, port byte build, output register.
// ---------------------------------------------------------------------------
module clns_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [2:0]         cfg_wdata,
  input  logic [1:0]         in_mode,
  input  logic [7:0]         in_value,
  input  logic [1:0]         in_row,
  input  logic [5:0]         in_col,
  input  clns_pkg::cmd_t     cmd,
  output clns_pkg::status_t  sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_port_byte,
  output logic [15:0]        out_wait_us,
  output logic               out_last
);

  logic [2:0]  display_flags_r;
  logic [1:0]  entry_flags_r;
  logic [10:0] held_r;          // mode in [9:8], sent byte in [7:0]
  logic [7:0]  sent;
  logic [6:0]  cur_addr;
  logic        rs;
  logic [3:0]  nibble;
  logic [7:0]  byte_nxt;
  logic [15:0] wait_nxt;
  logic        valid_r;
  logic [7:0]  port_r;
  logic [15:0] wait_r;
  logic        last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_flags_r <= clns_pkg::DISPLAY_FLAGS_RST;
      entry_flags_r   <= clns_pkg::ENTRY_FLAGS_RST;
    end else if (cfg_we) begin
      unique case (clns_pkg::cfg_idx_t'(cfg_index))
        clns_pkg::CFG_DISPLAY_FLAGS: display_flags_r <= cfg_wdata;
        clns_pkg::CFG_ENTRY_FLAGS:   entry_flags_r   <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // cursor address wraps within 7 bits
  assign cur_addr = {1'b0, in_col} + clns_pkg::row_offset(in_row);

  always_comb begin
    unique case (clns_pkg::mode_t'(in_mode))
      clns_pkg::MODE_CMD, clns_pkg::MODE_DATA: sent = in_value;
      clns_pkg::MODE_CURSOR:                   sent = {1'b1, cur_addr};
      default:                                 sent = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (cmd.load) begin
      held_r <= {1'b0, in_mode, sent};
    end
  end

  assign rs = (clns_pkg::mode_t'(held_r[9:8]) == clns_pkg::MODE_DATA);

  always_comb begin
    if (cmd.script) begin
      nibble = clns_pkg::script_nibble(cmd.nib, display_flags_r, entry_flags_r);
    end else begin
      nibble = cmd.nib[0] ? held_r[3:0] : held_r[7:4];
    end
    byte_nxt = {nibble, 3'b000, rs};
    if (cmd.phase == clns_pkg::PH_EN_HI) begin
      byte_nxt = byte_nxt | clns_pkg::PORT_ENABLE;
    end
    wait_nxt = clns_pkg::WAIT_NONE;
    if (cmd.phase == clns_pkg::PH_EN_LO && cmd.script) begin
      wait_nxt = clns_pkg::script_wait(cmd.nib);
    end
    if (cmd.pre) begin
      byte_nxt = 8'h00;
      wait_nxt = clns_pkg::WAIT_POWERUP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.emit) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      port_r <= byte_nxt;
      wait_r <= wait_nxt;
      last_r <= cmd.last;
    end
  end

  assign sts.out_free  = !valid_r || out_ready;
  assign out_valid     = valid_r;
  assign out_port_byte = port_r;
  assign out_wait_us   = wait_r;
  assign out_last      = last_r;

endmodule

// ===== sv/char_lcd_nibble_sequencer_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core
// Character-LCD request to I/O-expander byte stream, 4-bit bus.
// ---------------------------------------------------------------------------
// Takes one request at a time and emits the expander port bytes it causes,
// one per cycle while the result side keeps taking them. Command, data and
// cursor requests give six bytes each (one accept step, then one byte per
// cycle from the controller's nibble/phase counter); the reset script gives
// 43 bytes. Stalls on the result side hold the controller where it is. A
// result register sits between the sequencer and out_ch, so the next
// request is taken while the final byte of the previous one still waits.
// Port layout: nibble in bits 7..4, enable in bit 2, register select in
// bit 0, others 0. wait_us tells the consumer how long to hold off after
// that byte; last marks the final byte of a request. Write cfg_* only
// while the block is idle.
// ---------------------------------------------------------------------------
module char_lcd_nibble_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [2:0]  cfg_wdata,
  clns_req_if.sink    in_ch,
  clns_res_if.source  out_ch
);

  clns_pkg::cmd_t    cmd;
  clns_pkg::status_t sts;

  // controller: one-hot FSM, nibble and enable-phase counters
  clns_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: held request, script tables, result register
  clns_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_mode       (in_ch.mode),
    .in_value      (in_ch.value),
    .in_row        (in_ch.row),
    .in_col        (in_ch.col),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_port_byte (out_ch.port_byte),
    .out_wait_us   (out_ch.wait_us),
    .out_last      (out_ch.last)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for char_lcd_nibble_sequencer_core.
// ---------------------------------------------------------------------------
// Requests go in over in_ch. For each transfer the bench works out the
// expander bytes the request should produce, including the 43-byte init
// script built from the current flag registers. Every transfer on out_ch is
// compared in order against that stream. Both channels idle at random, with
// one phase that never idles. The flag registers are rewritten only once
// the block has drained.
// ---------------------------------------------------------------------------
module tb;

  localparam int RUN_LIMIT_NS = 5_000_000;
  localparam int IDLE_GAP     = 8;     // cycles after the final byte before cfg writes
  localparam int RAND_PHASES  = 5;
  localparam int PHASE_ITEMS  = 88;
  localparam int CALM_PHASE   = 2;     // phase where neither side idles

  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  localparam logic [3:0] NIB_WAKE = 4'h3;   // 8-bit wake-up nibble
  localparam logic [3:0] NIB_4BIT = 4'h2;   // switch to 4-bit bus

  localparam logic [7:0] CMD_FUNC_4BIT    = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_CTRL = 8'h08;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h04;
  localparam logic [7:0] CMD_HOME         = 8'h02;
  localparam logic [7:0] PORT_IDLE        = 8'h00;

  typedef struct packed {
    logic [7:0]  port_byte;
    logic [15:0] wait_us;
    logic        last;
  } lcd_beat_t;

  // Predicts the expander byte stream and checks it in order.
  class lcd_stream_board_t;
    lcd_beat_t  pending[$];
    logic [2:0] disp_flags;
    logic [1:0] entry_flags;
    int         errors;

    function new();
      disp_flags  = clns_pkg::DISPLAY_FLAGS_RST;
      entry_flags = clns_pkg::ENTRY_FLAGS_RST;
      errors      = 0;
    endfunction

    function void write_reg(clns_pkg::cfg_idx_t idx, logic [2:0] d);
      if (idx == clns_pkg::CFG_DISPLAY_FLAGS) begin
        disp_flags = d;
      end else begin
        entry_flags = d[1:0];
      end
    endfunction

    function void add_beat(logic [7:0] p, logic [15:0] w);
      lcd_beat_t b;
      b.port_byte = p;
      b.wait_us   = w;
      b.last      = 1'b0;
      pending.push_back(b);
    endfunction

    // plain, enable high, enable low; the wait sits on the falling strobe
    function void add_nibble(logic [3:0] n, logic rs, logic [15:0] w);
      logic [7:0] b;
      b = {n, 3'b000, rs};
      add_beat(b, clns_pkg::WAIT_NONE);
      add_beat(b | clns_pkg::PORT_ENABLE, clns_pkg::WAIT_NONE);
      add_beat(b, w);
    endfunction

    function void add_byte(logic [7:0] v, logic rs, logic [15:0] w);
      add_nibble(v[7:4], rs, clns_pkg::WAIT_NONE);
      add_nibble(v[3:0], rs, w);
    endfunction

    function void note_request(clns_pkg::mode_t m, logic [7:0] v, logic [1:0] r,
                               logic [5:0] c);
      logic [6:0] off;
      logic [6:0] addr;
      lcd_beat_t  tail;
      unique case (m)
        clns_pkg::MODE_CMD:  add_byte(v, RS_CMD, clns_pkg::WAIT_NONE);
        clns_pkg::MODE_DATA: add_byte(v, RS_DATA, clns_pkg::WAIT_NONE);
        clns_pkg::MODE_CURSOR: begin
          unique case (r)
            2'd0:    off = 7'h00;
            2'd1:    off = 7'h40;
            2'd2:    off = 7'h14;
            default: off = 7'h54;
          endcase
          addr = {1'b0, c} + off;   // wraps inside the 7-bit DDRAM address
          add_byte({1'b1, addr}, RS_CMD, clns_pkg::WAIT_NONE);
        end
        default: begin
          add_beat(PORT_IDLE, clns_pkg::WAIT_POWERUP);
          add_nibble(NIB_WAKE, RS_CMD, clns_pkg::WAIT_LONG);
          add_nibble(NIB_WAKE, RS_CMD, clns_pkg::WAIT_LONG);
          add_nibble(NIB_WAKE, RS_CMD, clns_pkg::WAIT_SHORT);
          add_nibble(NIB_4BIT, RS_CMD, clns_pkg::WAIT_NONE);
          add_byte(CMD_FUNC_4BIT, RS_CMD, clns_pkg::WAIT_NONE);
          add_byte(CMD_DISPLAY_CTRL | {5'b0, disp_flags}, RS_CMD, clns_pkg::WAIT_NONE);
          add_byte(CMD_CLEAR, RS_CMD, clns_pkg::WAIT_CLEAR);
          add_byte(CMD_ENTRY_MODE | {6'b0, entry_flags}, RS_CMD, clns_pkg::WAIT_NONE);
          add_byte(CMD_HOME, RS_CMD, clns_pkg::WAIT_CLEAR);
        end
      endcase
      tail = pending.pop_back();
      tail.last = 1'b1;
      pending.push_back(tail);
    endfunction

    function void check_beat(logic [7:0] p, logic [15:0] w, logic l);
      lcd_beat_t want;
      if (pending.size() == 0) begin
        $display("%0t: stray transfer expected none actual port_byte=%h wait_us=%0d last=%b",
                 $time, p, w, l);
        errors++;
      end else begin
        want = pending.pop_front();
        if (want.port_byte !== p) begin
          $display("%0t: port_byte expected %h actual %h", $time, want.port_byte, p);
          errors++;
        end
        if (want.wait_us !== w) begin
          $display("%0t: wait_us expected %0d actual %0d", $time, want.wait_us, w);
          errors++;
        end
        if (want.last !== l) begin
          $display("%0t: last expected %b actual %b", $time, want.last, l);
          errors++;
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [0:0] cfg_index;
  logic [2:0] cfg_wdata;
  logic       calm = 1'b0;

  lcd_stream_board_t board;

  clns_req_if req_ch();
  clns_res_if res_ch();

  char_lcd_nibble_sequencer_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (req_ch),
    .out_ch   (res_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Holds valid until the transfer, then books the request's byte stream.
  task automatic send_req(clns_pkg::mode_t m, logic [7:0] v, logic [1:0] r,
                          logic [5:0] c);
    while (!calm && $urandom_range(99) < 7) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode  <= m;
    req_ch.value <= v;
    req_ch.row   <= r;
    req_ch.col   <= c;
    do @(posedge clk); while (!req_ch.ready);
    board.note_request(m, v, r, c);
  endtask

  // Mostly in-range columns; some push the address past 7 bits.
  task automatic send_random();
    int               pick;
    clns_pkg::mode_t  m;
    logic [5:0]       c;
    pick = $urandom_range(99);
    if (pick < 30) begin
      m = clns_pkg::MODE_CMD;
    end else if (pick < 60) begin
      m = clns_pkg::MODE_DATA;
    end else if (pick < 88) begin
      m = clns_pkg::MODE_CURSOR;
    end else begin
      m = clns_pkg::MODE_RESET;
    end
    if ($urandom_range(4) == 0) begin
      c = 6'($urandom_range(63));
    end else begin
      c = 6'($urandom_range(39));
    end
    send_req(m, 8'($urandom), 2'($urandom), c);
  endtask

  // Sender holds off until every booked byte is out, then lets the core settle.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  // Spare wdata bit on the entry register is driven at random; the core drops it.
  task automatic set_flags(logic [2:0] df, logic [1:0] ef);
    logic [2:0] ew;
    ew = {1'($urandom), ef};
    cfg_we    <= 1'b1;
    cfg_index <= clns_pkg::CFG_DISPLAY_FLAGS;
    cfg_wdata <= df;
    @(posedge clk);
    board.write_reg(clns_pkg::CFG_DISPLAY_FLAGS, df);
    cfg_index <= clns_pkg::CFG_ENTRY_FLAGS;
    cfg_wdata <= ew;
    @(posedge clk);
    board.write_reg(clns_pkg::CFG_ENTRY_FLAGS, ew);
    cfg_we <= 1'b0;
  endtask

  // Result side: check each transfer, then decide next cycle's ready.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_ch.valid && res_ch.ready) begin
        board.check_beat(res_ch.port_byte, res_ch.wait_us, res_ch.last);
      end
      res_ch.ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  initial begin
    board = new();
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= clns_pkg::CFG_DISPLAY_FLAGS;
    cfg_wdata    <= '0;
    req_ch.valid <= 1'b0;
    req_ch.mode  <= clns_pkg::MODE_CMD;
    req_ch.value <= '0;
    req_ch.row   <= '0;
    req_ch.col   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte extremes, every cursor row, address wrap, and the
    // init script with ignored fields at their maximum, on reset flags.
    send_req(clns_pkg::MODE_CMD,    8'h00, 2'd0, 6'd0);
    send_req(clns_pkg::MODE_CMD,    8'hff, 2'd3, 6'd63);
    send_req(clns_pkg::MODE_DATA,   8'h00, 2'd0, 6'd0);
    send_req(clns_pkg::MODE_DATA,   8'hff, 2'd3, 6'd63);
    send_req(clns_pkg::MODE_DATA,   8'ha5, 2'd1, 6'd21);
    send_req(clns_pkg::MODE_CURSOR, 8'h00, 2'd0, 6'd0);
    send_req(clns_pkg::MODE_CURSOR, 8'h00, 2'd1, 6'd39);
    send_req(clns_pkg::MODE_CURSOR, 8'h00, 2'd2, 6'd39);
    send_req(clns_pkg::MODE_CURSOR, 8'h00, 2'd3, 6'd39);
    send_req(clns_pkg::MODE_CURSOR, 8'h00, 2'd3, 6'd63);
    send_req(clns_pkg::MODE_CURSOR, 8'hff, 2'd1, 6'd63);
    send_req(clns_pkg::MODE_RESET,  8'hff, 2'd3, 6'd63);
    send_req(clns_pkg::MODE_CMD,    8'h5a, 2'd0, 6'd0);

    // Flag extremes through the init script.
    wait_idle();
    set_flags(3'd7, 2'd3);
    send_req(clns_pkg::MODE_RESET,  8'h00, 2'd0, 6'd0);
    send_req(clns_pkg::MODE_DATA,   8'h3c, 2'd2, 6'd5);
    wait_idle();
    set_flags(3'd0, 2'd0);
    send_req(clns_pkg::MODE_RESET,  8'h81, 2'd2, 6'd40);
    send_req(clns_pkg::MODE_CURSOR, 8'h00, 2'd2, 6'd0);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      set_flags(3'($urandom), 2'($urandom));
      calm <= (ph == CALM_PHASE);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_random();
      end
    end

    calm <= 1'b0;
    wait_idle();
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
